@@ src/rle_pkg.sv @@
// Shared types and constants for the run-length byte encoder.
// No dependencies; all src/ files but rle_ram refer to this package by scoped names.
package rle_pkg;

  // Format limits.
  localparam int MAX_LITERAL = 128;
  localparam int MAX_RUN     = 130;
  localparam int MIN_RUN     = 3;
  localparam int OUT_BYTES   = 8;

  // Derived widths.
  localparam int BYTE_W = 8;
  localparam int LIT_AW = $clog2(MAX_LITERAL);
  localparam int LIT_CW = $clog2(MAX_LITERAL + 1);
  localparam int RUN_CW = $clog2(MAX_RUN + 1);
  localparam int PACK_W = OUT_BYTES * BYTE_W;
  localparam int CNT_W  = 4;
  localparam int IDX_W  = $clog2(OUT_BYTES);

  // Command queue between the front and back parts.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PW    = $clog2(CMD_DEPTH);

  // A run header is 0x80 plus the run length minus the minimum run.
  localparam logic [BYTE_W-1:0] RUN_FLAG = 8'h80;
  localparam logic [BYTE_W-1:0] RUN_BASE = BYTE_W'(RUN_FLAG - BYTE_W'(MIN_RUN));

  // Command codes.
  typedef logic [1:0] op_t;
  localparam op_t OP_ADD   = 2'd0;
  localparam op_t OP_FLUSH = 2'd1;
  localparam op_t OP_RUN   = 2'd2;

  // One command: add count literals of value, flush the literal block, or emit a run.
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] value;
    logic [RUN_CW-1:0] count;
    logic              last;
    logic              fin;
  } cmd_t;

  // Byte and close requests from the back part to the packer.
  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              close;
    logic              fin;
  } pack_req_t;

  typedef struct packed {
    logic byte_ready;
    logic close_ready;
  } pack_ack_t;

endpackage

@@ src/rle_byte_encoder_core.sv @@
// Top level of the run-length byte encoder.
// Depends on rle_pkg, rle_front, rle_cmd_fifo, rle_back and rle_pack.

// The encoder takes one byte per transfer and writes a run-length format: runs
// of 3 to 130 equal bytes become a flag byte and the value, all other bytes are
// gathered into literal blocks of up to 128 bytes behind a length byte. Output
// bytes are packed up to eight per result; step_done marks the last result caused
// by an input byte and stream_done the last one of the stream. The front takes
// input bytes while the four-entry command queue has room and no stream is being
// finished; a byte with final_byte set holds it while it settles the pending run
// and issues the final flush. The back, which sets the sustained rate, takes each
// command, writes each literal to the block RAM, hands each output byte to the
// packer and closes each step that issued a command; a full literal block drains
// as its length byte and its 128 bytes. A byte that extends a run issues no command
// unless the run reaches its minimum or maximum length; in a stream of distinct
// bytes each byte brings a command that adds one literal and closes the step. The
// back stalls only while the result register waits to be taken.
module rle_byte_encoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [rle_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          final_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [rle_pkg::PACK_W-1:0]    packed_bytes,
  output logic [rle_pkg::CNT_W-1:0]     byte_count,
  output logic                          step_done,
  output logic                          stream_done
);

  logic                 cmd_push;
  rle_pkg::cmd_t        cmd_in;
  logic                 q_full;
  logic                 q_pop;
  rle_pkg::cmd_t        q_data;
  logic                 q_empty;
  rle_pkg::pack_req_t   pack_req;
  rle_pkg::pack_ack_t   pack_ack;

  // Input classification.
  rle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .q_full     (q_full)
  );

  // Command queue.
  rle_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Command execution and literal store.
  rle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .req     (pack_req),
    .ack     (pack_ack)
  );

  // Byte packing and result register.
  rle_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .req          (pack_req),
    .ack          (pack_ack),
    .empty        (empty),
    .pop          (pop),
    .packed_bytes (packed_bytes),
    .byte_count   (byte_count),
    .step_done    (step_done),
    .stream_done  (stream_done)
  );

endmodule

@@ src/rle_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rle_front.sv @@
// Front part: accepts input bytes, tracks the pending run and issues commands.
// Depends on rle_pkg.
module rle_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [rle_pkg::BYTE_W-1:0]   data_byte,
  input  logic                         final_byte,
  output logic                         cmd_push,
  output rle_pkg::cmd_t                cmd,
  input  logic                         q_full
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SETTLE = 2'd1;
  localparam logic [1:0] PH_FLUSH  = 2'd2;

  logic [1:0]                       phase, phase_next;
  logic [rle_pkg::BYTE_W-1:0]       run_value, run_value_next;
  logic [rle_pkg::RUN_CW-1:0]       run_count, run_count_next;
  logic [rle_pkg::RUN_CW-1:0]       run_inc;
  logic                             run_match;
  rle_pkg::op_t                     settle_op;

  // The front reports full while it finishes a stream or the command queue is full.
  assign full      = (phase != PH_IDLE) || q_full;
  assign run_inc   = rle_pkg::RUN_CW'(run_count + 1'b1);
  assign run_match = (run_count != '0) && (data_byte == run_value);
  assign settle_op = (run_count >= rle_pkg::RUN_CW'(rle_pkg::MIN_RUN)) ?
                     rle_pkg::OP_RUN : rle_pkg::OP_ADD;

  // Classify the byte against the pending run and choose the command.
  always_comb begin
    phase_next     = phase;
    run_value_next = run_value;
    run_count_next = run_count;
    cmd_push       = 1'b0;
    cmd            = '0;
    unique case (phase)
      PH_IDLE: begin
        if (push && !q_full) begin
          if (run_match) begin
            if (run_inc == rle_pkg::RUN_CW'(rle_pkg::MIN_RUN)) begin
              cmd_push = 1'b1;
              cmd.op   = rle_pkg::OP_FLUSH;
            end else if (run_inc >= rle_pkg::RUN_CW'(rle_pkg::MAX_RUN)) begin
              cmd_push = 1'b1;
              cmd.op   = rle_pkg::OP_RUN;
            end
            cmd.count      = run_inc;
            cmd.value      = run_value;
            run_count_next = (run_inc >= rle_pkg::RUN_CW'(rle_pkg::MAX_RUN)) ? '0 : run_inc;
          end else begin
            // A different byte settles the pending run and starts a new one.
            cmd_push       = (run_count != '0);
            cmd.op         = settle_op;
            cmd.count      = run_count;
            cmd.value      = run_value;
            run_value_next = data_byte;
            run_count_next = rle_pkg::RUN_CW'(1);
          end
          cmd.last = !final_byte;
          if (final_byte) begin
            phase_next = PH_SETTLE;
          end
        end
      end
      PH_SETTLE: begin
        if (!q_full) begin
          cmd_push       = (run_count != '0);
          cmd.op         = settle_op;
          cmd.count      = run_count;
          cmd.value      = run_value;
          run_count_next = '0;
          phase_next     = PH_FLUSH;
        end
      end
      PH_FLUSH: begin
        if (!q_full) begin
          cmd_push   = 1'b1;
          cmd.op     = rle_pkg::OP_FLUSH;
          cmd.last   = 1'b1;
          cmd.fin    = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Run state and phase registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      run_value <= '0;
      run_count <= '0;
    end else begin
      phase     <= phase_next;
      run_value <= run_value_next;
      run_count <= run_count_next;
    end
  end

  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    run_count < rle_pkg::RUN_CW'(rle_pkg::MAX_RUN))
    else $error("pending run reached its limit without being emitted");

endmodule

@@ src/rle_cmd_fifo.sv @@
// Short command queue that lets the front and back parts stall independently.
// Depends on rle_pkg.
module rle_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rle_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          pop,
  output rle_pkg::cmd_t rd_data,
  output logic          empty
);

  rle_pkg::cmd_t               slots [rle_pkg::CMD_DEPTH];
  logic [rle_pkg::CMD_PW-1:0]  wr_ptr, rd_ptr;
  logic [rle_pkg::CMD_PW:0]    fill;
  logic                        do_push, do_pop;

  assign full    = (fill == (rle_pkg::CMD_PW + 1)'(rle_pkg::CMD_DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= rle_pkg::CMD_PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= rle_pkg::CMD_PW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        fill <= (rle_pkg::CMD_PW + 1)'(fill + 1'b1);
      end else if (do_pop && !do_push) begin
        fill <= (rle_pkg::CMD_PW + 1)'(fill - 1'b1);
      end
    end
  end

endmodule

@@ src/rle_pack.sv @@
// Packer: gathers output bytes into words of up to eight and holds the result register.
// Depends on rle_pkg.
module rle_pack (
  input  logic                          clk,
  input  logic                          rst,
  input  rle_pkg::pack_req_t            req,
  output rle_pkg::pack_ack_t            ack,
  output logic                          empty,
  input  logic                          pop,
  output logic [rle_pkg::PACK_W-1:0]    packed_bytes,
  output logic [rle_pkg::CNT_W-1:0]     byte_count,
  output logic                          step_done,
  output logic                          stream_done
);

  logic [rle_pkg::PACK_W-1:0] acc;
  logic [rle_pkg::CNT_W-1:0]  acc_cnt;
  logic [rle_pkg::IDX_W-1:0]  acc_idx;
  logic                       acc_full;
  logic                       out_valid;
  logic                       out_free;
  logic                       byte_take;
  logic                       close_take;
  logic                       load;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign acc_idx  = acc_cnt[rle_pkg::IDX_W-1:0];
  assign acc_full = (acc_cnt == rle_pkg::CNT_W'(rle_pkg::OUT_BYTES));

  // A full word is held until a further byte or a close shows whether it ends the step.
  assign ack.byte_ready  = !acc_full || out_free;
  assign ack.close_ready = (acc_cnt == '0) || out_free;

  // The result register is loaded by a byte that finds the word full or by a close.
  assign byte_take  = req.byte_valid && ack.byte_ready;
  assign close_take = req.close && ack.close_ready && (acc_cnt != '0);
  assign load       = (byte_take && acc_full) || (!byte_take && close_take);

  // Accumulator and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      acc_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (byte_take) begin
        if (acc_full) begin
          packed_bytes <= acc;
          byte_count   <= acc_cnt;
          step_done    <= 1'b0;
          stream_done  <= 1'b0;
          acc          <= rle_pkg::PACK_W'(req.byte_data);
          acc_cnt      <= rle_pkg::CNT_W'(1);
        end else begin
          acc[{acc_idx, 3'b000} +: rle_pkg::BYTE_W] <= req.byte_data;
          acc_cnt <= rle_pkg::CNT_W'(acc_cnt + 1'b1);
        end
      end else if (close_take) begin
        packed_bytes <= acc;
        byte_count   <= acc_cnt;
        step_done    <= 1'b1;
        stream_done  <= req.fin;
        acc          <= '0;
        acc_cnt      <= '0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != '0) && (byte_count <= rle_pkg::CNT_W'(rle_pkg::OUT_BYTES)))
    else $error("result word holds an invalid byte count");

  a_stream_ends_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_done) |-> step_done)
    else $error("stream end flagged on a result that does not end its step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid && $stable(packed_bytes) && $stable(byte_count))
    else $error("waiting result was changed before it was taken");

endmodule

@@ src/rle_back.sv @@
// Back part: executes commands, keeps the literal block in RAM and feeds the packer.
// Depends on rle_pkg and rle_ram.
module rle_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  rle_pkg::cmd_t        q_data,
  output logic                 q_pop,
  output rle_pkg::pack_req_t   req,
  input  rle_pkg::pack_ack_t   ack
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_HDR   = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_RUN0  = 3'd4;
  localparam logic [2:0] ST_RUN1  = 3'd5;
  localparam logic [2:0] ST_CLOSE = 3'd6;

  logic [2:0]                      state, state_next;
  rle_pkg::cmd_t                   cmd, cmd_next;
  logic [rle_pkg::RUN_CW-1:0]      rem, rem_next;
  logic [rle_pkg::LIT_CW-1:0]      lit_count, lit_count_next;
  logic [rle_pkg::LIT_AW-1:0]      rd_idx, rd_idx_next;
  logic [rle_pkg::LIT_CW-1:0]      lit_last;
  logic [2:0]                      done_state;
  logic                            ram_we;
  logic [rle_pkg::BYTE_W-1:0]      ram_rdata;

  // Literal block store; read at rd_idx_next, so rdata holds the byte at rd_idx.
  rle_ram #(
    .WIDTH (rle_pkg::BYTE_W),
    .DEPTH (rle_pkg::MAX_LITERAL)
  ) u_lit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lit_count[rle_pkg::LIT_AW-1:0]),
    .wdata (cmd.value),
    .raddr (rd_idx_next),
    .rdata (ram_rdata)
  );

  assign lit_last   = rle_pkg::LIT_CW'(lit_count - 1'b1);
  assign done_state = cmd.last ? ST_CLOSE : ST_IDLE;

  // Command sequencer.
  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    rem_next       = rem;
    lit_count_next = lit_count;
    rd_idx_next    = rd_idx;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    req            = '0;
    req.fin        = cmd.fin;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cmd_next = q_data;
          rem_next = (q_data.op == rle_pkg::OP_ADD) ? q_data.count : '0;
          case (q_data.op)
            rle_pkg::OP_ADD:   state_next = ST_ADD;
            rle_pkg::OP_RUN:   state_next = ST_RUN0;
            rle_pkg::OP_FLUSH: begin
              if (lit_count != '0) begin
                state_next = ST_HDR;
              end else begin
                state_next = q_data.last ? ST_CLOSE : ST_IDLE;
              end
            end
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        // One literal per cycle; a full block is flushed before the next one.
        ram_we         = 1'b1;
        lit_count_next = rle_pkg::LIT_CW'(lit_count + 1'b1);
        rem_next       = rle_pkg::RUN_CW'(rem - 1'b1);
        if (lit_count_next == rle_pkg::LIT_CW'(rle_pkg::MAX_LITERAL)) begin
          state_next = ST_HDR;
        end else if (rem_next == '0) begin
          state_next = done_state;
        end
      end
      ST_HDR: begin
        req.byte_valid = 1'b1;
        req.byte_data  = rle_pkg::BYTE_W'(lit_last);
        rd_idx_next    = '0;
        if (ack.byte_ready) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        req.byte_valid = 1'b1;
        req.byte_data  = ram_rdata;
        if (ack.byte_ready) begin
          if ({1'b0, rd_idx} == lit_last) begin
            lit_count_next = '0;
            state_next     = (rem != '0) ? ST_ADD : done_state;
          end else begin
            rd_idx_next = rle_pkg::LIT_AW'(rd_idx + 1'b1);
          end
        end
      end
      ST_RUN0: begin
        req.byte_valid = 1'b1;
        req.byte_data  = rle_pkg::BYTE_W'(rle_pkg::RUN_BASE + cmd.count);
        if (ack.byte_ready) begin
          state_next = ST_RUN1;
        end
      end
      ST_RUN1: begin
        req.byte_valid = 1'b1;
        req.byte_data  = cmd.value;
        if (ack.byte_ready) begin
          state_next = done_state;
        end
      end
      ST_CLOSE: begin
        // End of the step: the packer releases its partial word.
        req.close = 1'b1;
        if (ack.close_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lit_count <= '0;
    end else begin
      state     <= state_next;
      lit_count <= lit_count_next;
    end
    cmd    <= cmd_next;
    rem    <= rem_next;
    rd_idx <= rd_idx_next;
  end

  a_lit_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (lit_count < rle_pkg::LIT_CW'(rle_pkg::MAX_LITERAL)))
    else $error("literal block left full between commands");

endmodule

@@ test/rle_scoreboard_pkg.sv @@
// Scoreboard for the run-length byte encoder: a predictor of the output stream and the
// queue of results still due. Depends on rle_pkg for the format limits and widths.
package rle_scoreboard_pkg;

  // One expected result, field by field as the block presents it.
  typedef struct {
    logic [rle_pkg::PACK_W-1:0] word;
    logic [rle_pkg::CNT_W-1:0]  nbytes;
    logic                       step_end;
    logic                       stream_end;
  } rle_word_t;

  class rle_encoder_scoreboard_t;
    rle_word_t   words_due[$];
    logic [7:0]  block_buf[rle_pkg::MAX_LITERAL];
    int unsigned block_len;
    logic [7:0]  run_val;
    int unsigned run_len;
    logic [7:0]  step_out[$];
    int unsigned mismatches;

    function new();
      block_len  = 0;
      run_val    = '0;
      run_len    = 0;
      mismatches = 0;
    endfunction

    // Append one output byte of the current step.
    function void put_byte(logic [7:0] v);
      step_out = {step_out, v};
    endfunction

    // Write out the pending literal block as a length byte and its verbatim bytes.
    function void flush_block();
      if (block_len == 0) return;
      put_byte(8'(block_len - 1));
      for (int i = 0; i < block_len; i++) put_byte(block_buf[i]);
      block_len = 0;
    endfunction

    // Append one literal; a full block goes out at once.
    function void add_to_block(logic [7:0] v);
      block_buf[block_len] = v;
      block_len++;
      if (block_len >= rle_pkg::MAX_LITERAL) flush_block();
    endfunction

    // Write out the pending run as a flag byte and the repeated value.
    function void emit_run();
      put_byte(8'(rle_pkg::RUN_FLAG + run_len - rle_pkg::MIN_RUN));
      put_byte(run_val);
      run_len = 0;
    endfunction

    // A run that is long enough is emitted; a shorter one joins the literal block.
    function void settle_run();
      if (run_len >= rle_pkg::MIN_RUN) begin
        emit_run();
      end else begin
        for (int i = 0; i < run_len; i++) add_to_block(run_val);
        run_len = 0;
      end
    endfunction

    // Advance the encoder by one accepted input and queue the results it causes.
    function void note_byte(logic [7:0] d, logic fin);
      int unsigned pos;
      int unsigned cnt;
      rle_word_t   w;
      step_out.delete();
      if (run_len > 0 && d == run_val) begin
        run_len++;
        if (run_len == rle_pkg::MIN_RUN) flush_block();
        if (run_len >= rle_pkg::MAX_RUN) emit_run();
      end else begin
        settle_run();
        run_val = d;
        run_len = 1;
      end
      if (fin) begin
        settle_run();
        flush_block();
      end
      // Pack the bytes of this step, first byte in the low bits.
      pos = 0;
      while (pos < step_out.size()) begin
        cnt = step_out.size() - pos;
        if (cnt > rle_pkg::OUT_BYTES) cnt = rle_pkg::OUT_BYTES;
        w.word = '0;
        for (int i = 0; i < cnt; i++) w.word[8*i +: 8] = step_out[pos + i];
        pos += cnt;
        w.nbytes     = cnt[rle_pkg::CNT_W-1:0];
        w.step_end   = (pos >= step_out.size());
        w.stream_end = w.step_end && fin;
        words_due = {words_due, w};
      end
    endfunction

    // Compare one accepted result with the oldest one due.
    function void check_word(logic [rle_pkg::PACK_W-1:0] word, logic [rle_pkg::CNT_W-1:0] nbytes,
                             logic step_end, logic stream_end);
      rle_word_t want;
      if (words_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got packed_bytes %h byte_count %0d",
                 $time, word, nbytes);
        mismatches++;
        return;
      end
      want = words_due.pop_front();
      if (word !== want.word) begin
        $display("%0t: packed_bytes expected %h, got %h", $time, want.word, word);
        mismatches++;
      end
      if (nbytes !== want.nbytes) begin
        $display("%0t: byte_count expected %0d, got %0d", $time, want.nbytes, nbytes);
        mismatches++;
      end
      if (step_end !== want.step_end) begin
        $display("%0t: step_done expected %b, got %b", $time, want.step_end, step_end);
        mismatches++;
      end
      if (stream_end !== want.stream_end) begin
        $display("%0t: stream_done expected %b, got %b", $time, want.stream_end, stream_end);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return words_due.size();
    endfunction
  endclass

endpackage

@@ test/tb_top.sv @@
// Top-level testbench for rle_byte_encoder_core: directed and random byte streams,
// checked transfer by transfer against the scoreboard. Depends on rle_pkg and
// rle_scoreboard_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS  = 65;

  typedef enum int {SEG_RUN, SEG_LITERAL, SEG_NOISE, SEG_END} seg_kind_t;

  logic                         clk        = 1'b0;
  logic                         rst        = 1'b1;
  logic                         push       = 1'b0;
  logic                         full;
  logic [rle_pkg::BYTE_W-1:0]   data_byte  = '0;
  logic                         final_byte = 1'b0;
  logic                         empty;
  logic                         pop        = 1'b0;
  logic [rle_pkg::PACK_W-1:0]   packed_bytes;
  logic [rle_pkg::CNT_W-1:0]    byte_count;
  logic                         step_done;
  logic                         stream_done;

  rle_scoreboard_pkg::rle_encoder_scoreboard_t sb;
  int          send_idle = 23;
  int          recv_idle = 79;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  last_sent = '0;

  rle_byte_encoder_core uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .final_byte   (final_byte),
    .empty        (empty),
    .pop          (pop),
    .packed_bytes (packed_bytes),
    .byte_count   (byte_count),
    .step_done    (step_done),
    .stream_done  (stream_done)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver takes results with a random stall rate.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Note every accepted input before checking the result of the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_byte(data_byte, final_byte);
      if (pop && !empty) sb.check_word(packed_bytes, byte_count, step_done, stream_done);
    end
  end

  // Watchdog: too many cycles in a row without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one byte, with random idle cycles first, and wait for its transfer.
  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    data_byte  <= d;
    final_byte <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    last_sent = d;
    items_sent++;
  endtask

  // A run of equal bytes; the stream may end on its last byte.
  task automatic send_run(input logic [7:0] v, input int len, input logic fin);
    for (int i = 0; i < len; i++) send_byte(v, fin && (i == len - 1));
  endtask

  // Bytes that each differ from the one before them.
  task automatic send_literals(input int len, input logic fin);
    logic [7:0] v;
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom);
      if (v == last_sent) v = v ^ 8'h01;
      send_byte(v, fin && (i == len - 1));
    end
  endtask

  // Random segments until the phase has sent its share of bytes.
  task automatic random_phase(input int unsigned target);
    seg_kind_t  kind;
    int         pick;
    int         len;
    logic       fin;
    logic [7:0] v;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      kind = (pick < 35) ? SEG_RUN : (pick < 70) ? SEG_LITERAL : (pick < 92) ? SEG_NOISE : SEG_END;
      fin  = ($urandom_range(99) < 12);
      case (kind)
        SEG_RUN: begin
          len = ($urandom_range(19) == 0) ? $urandom_range(128, 135) : $urandom_range(1, 6);
          v   = $urandom_range(1) ? last_sent : 8'($urandom);
          send_run(v, len, fin);
        end
        SEG_LITERAL: begin
          len = ($urandom_range(24) == 0) ? $urandom_range(126, 135) : $urandom_range(1, 12);
          send_literals(len, fin);
        end
        SEG_NOISE: begin
          // A tiny alphabet gives many short runs that break early.
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(3)), ($urandom_range(99) < 5));
          end
        end
        default: begin
          send_byte(8'($urandom), 1'b1);
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed streams: single bytes at both extremes, a short run cut by the end,
    // a minimal run, a short run broken by another byte, and literals flushed when
    // a run is confirmed.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_run(8'h5A, 2, 1'b1);
    send_run(8'h11, 3, 1'b1);
    send_run(8'h22, 2, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_run(8'hAA, 3, 1'b0);
    send_byte(8'h55, 1'b1);

    // Fast sender, slow receiver; starts with a run that reaches its limit.
    send_run(8'($urandom), $urandom_range(130, 133), 1'b0);
    random_phase(items_sent + PHASE_ITEMS);

    // Roles swapped; starts with literals that fill at least one block.
    send_idle = 79;
    recv_idle = 23;
    send_literals($urandom_range(128, 131), 1'b0);
    random_phase(items_sent + PHASE_ITEMS);

    // Neither side idles.
    send_idle = 0;
    recv_idle = 0;
    random_phase(items_sent + PHASE_ITEMS);
    send_byte(8'($urandom), 1'b1);
    push <= 1'b0;

    // Drain, then give the block time to show any extra result.
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_top passed");
    end else begin
      if (sb.outstanding() > 0) $display("%0t: %0d results never arrived", $time, sb.outstanding());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ rle_byte_encoder_core.f @@
src/rle_pkg.sv
src/rle_ram.sv
src/rle_front.sv
src/rle_cmd_fifo.sv
src/rle_pack.sv
src/rle_back.sv
src/rle_byte_encoder_core.sv
test/rle_scoreboard_pkg.sv
test/tb_top.sv
